FILE: rtl/gha_pkg.sv
package gha_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);
    localparam int CNT_W      = SLOT_AW + 1;
    localparam int IDX_W      = 10;
    localparam int GEN_W      = 32;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;

    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SETP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GETP   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  handle_index;
        logic [GEN_W-1:0]  handle_gen;
        logic [IDX_W-1:0]  parent_index;
        logic [GEN_W-1:0]  parent_gen;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    out_index;
        logic [GEN_W-1:0]    out_gen;
        logic                is_live;
    } t_rsp;

    typedef struct packed {
        logic             live;
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] pidx;
        logic [GEN_W-1:0] pgen;
    } t_slot;

    typedef struct packed {
        logic accept;
        logic pop;
        logic fire;
    } t_cmd;

    typedef struct packed {
        logic create_pop;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/gha_ram.sv
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gha_ctrl.sv
module gha_ctrl
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.pop    = 1'b0;
        o_cmd.fire   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.create_pop ? S_POP : S_EXEC;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.fire = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_fire_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fire |=> r_state == S_IDLE)
        else $error("fire did not return to idle");

    a_pop_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |=> r_state == S_EXEC)
        else $error("pop not followed by exec");

    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_stall)
        else $error("request side not stalled after accept");

endmodule

FILE: rtl/gha_dp.sv
module gha_dp
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  logic i_stall,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_req               r_req;
    logic [SLOT_AW-1:0] r_slot;
    logic               r_from_stack;
    logic [CNT_W-1:0]   r_free_count;
    logic [CNT_W-1:0]   n_free_count;
    logic [CNT_W-1:0]   r_next_fresh;
    logic [CNT_W-1:0]   n_next_fresh;
    logic               r_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;

    logic               slot_we;
    t_slot              slot_wdata;
    logic [SLOT_AW-1:0] slot_raddr;
    logic [$bits(t_slot)-1:0] slot_rdata;
    logic               stack_we;
    logic [SLOT_AW-1:0] stack_rdata;
    logic [CNT_W-1:0]   free_dec;

    t_slot              ent;
    logic               written;
    logic               hit;
    logic               full;

    assign free_dec   = r_free_count - CNT_W'(1);
    assign slot_raddr = i_cmd.accept ? i_req.handle_index[SLOT_AW-1:0] : stack_rdata;

    gha_ram #(.WIDTH($bits(t_slot)), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_slot),
        .i_wdata (slot_wdata),
        .i_re    (i_cmd.accept | i_cmd.pop),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    gha_ram #(.WIDTH(SLOT_AW), .DEPTH(SLOT_COUNT)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_free_count[SLOT_AW-1:0]),
        .i_wdata (r_slot),
        .i_re    (i_cmd.accept),
        .i_raddr (free_dec[SLOT_AW-1:0]),
        .o_rdata (stack_rdata)
    );

    assign written = r_from_stack ||
                     ((r_req.handle_index != '0) &&
                      (CNT_W'(r_req.handle_index) < r_next_fresh));
    assign ent  = written ? t_slot'(slot_rdata) : '0;
    assign hit  = ent.live && (ent.gen == r_req.handle_gen);
    assign full = (r_next_fresh == CNT_W'(SLOT_COUNT));

    assign o_sts.create_pop = (i_req.mode == MODE_CREATE) && (r_free_count != '0);
    assign o_sts.out_busy   = r_valid && i_stall;

    always_comb begin
        n_rsp        = '0;
        slot_wdata   = ent;
        slot_we      = 1'b0;
        stack_we     = 1'b0;
        n_next_fresh = r_next_fresh;
        n_free_count = r_free_count;
        if (i_cmd.accept && (i_req.mode == MODE_CREATE) && (r_free_count != '0)) begin
            n_free_count = free_dec;
        end
        unique case (r_req.mode)
            MODE_CREATE: begin
                if (r_from_stack) begin
                    slot_wdata.live = 1'b1;
                    slot_wdata.gen  = ent.gen + GEN_W'(1);
                    slot_we         = i_cmd.fire;
                    n_rsp.out_index = IDX_W'(r_slot);
                    n_rsp.out_gen   = slot_wdata.gen;
                end else if (!full) begin
                    slot_wdata      = '0;
                    slot_wdata.live = 1'b1;
                    slot_we         = i_cmd.fire;
                    n_rsp.out_index = IDX_W'(r_slot);
                    if (i_cmd.fire) begin
                        n_next_fresh = r_next_fresh + CNT_W'(1);
                    end
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            MODE_DELETE, MODE_CHECK, MODE_SETP, MODE_GETP: begin
                n_rsp.is_live = hit;
                if (!hit) begin
                    n_rsp.status = ST_DEAD;
                end else if (r_req.mode == MODE_DELETE) begin
                    slot_wdata.live = 1'b0;
                    slot_wdata.pidx = '0;
                    slot_wdata.pgen = '0;
                    slot_we         = i_cmd.fire;
                    if (i_cmd.fire && (r_free_count < CNT_W'(SLOT_COUNT))) begin
                        stack_we     = 1'b1;
                        n_free_count = r_free_count + CNT_W'(1);
                    end
                end else if (r_req.mode == MODE_SETP) begin
                    slot_wdata.pidx = r_req.parent_index;
                    slot_wdata.pgen = r_req.parent_gen;
                    slot_we         = i_cmd.fire;
                end else if (r_req.mode == MODE_GETP) begin
                    n_rsp.out_index = ent.pidx;
                    n_rsp.out_gen   = ent.pgen;
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req;
            r_slot <= (i_req.mode == MODE_CREATE) ? r_next_fresh[SLOT_AW-1:0]
                                                  : i_req.handle_index[SLOT_AW-1:0];
        end else if (i_cmd.pop) begin
            r_slot <= stack_rdata;
        end
        if (i_cmd.fire) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_stack <= 1'b0;
            r_free_count <= '0;
            r_next_fresh <= CNT_W'(1);
            r_valid      <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_from_stack <= o_sts.create_pop;
            end
            r_free_count <= n_free_count;
            r_next_fresh <= n_next_fresh;
            if (i_cmd.fire) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_fresh != '0) && (r_next_fresh <= CNT_W'(SLOT_COUNT)))
        else $error("fresh slot counter out of range");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count < r_next_fresh)
        else $error("free stack holds more slots than were handed out");

    a_create_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && (r_req.mode == MODE_CREATE)) |=>
            ((o_rsp.status == ST_FULL) || (o_rsp.out_index != '0)))
        else $error("create returned the null slot");

    a_dead_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_DEAD)) |-> !o_rsp.is_live)
        else $error("dead status with live flag");

endmodule

FILE: rtl/generational_handle_allocator_core.sv
// Generational handle allocator.
// Request channel: i_valid / o_stall carrying i_req (mode, handle, parent).
// Response channel: o_valid / i_stall carrying o_rsp (status, index, gen,
// is_live). Each request yields exactly one response, in order.
// One request is processed at a time: o_stall is high from the cycle after
// acceptance until the response is loaded into the output register.
// The slot table and the free stack RAM both have registered reads. After
// acceptance, a create that pops the free stack passes a pop step (stack
// read, then slot table read) before the execute step; other requests go
// straight to it. The execute step writes the slot table back and loads the
// response into the output register, which raises o_valid.
// A new request is taken while the previous response waits in the output
// register; if the receiver holds i_stall, the next response waits in the
// execute step and the request side stalls behind it.
// Reset clears the control state, the free count and sets the fresh slot
// counter to one. Slot table entries beyond the fresh slot counter read as
// empty, so no clearing pass follows reset.
module generational_handle_allocator_core
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gha_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: verif/generational_handle_allocator_core_tb.sv
module generational_handle_allocator_core_tb;
    import gha_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
    localparam int unsigned       IDX_TOP    = SLOT_COUNT - 1;
    localparam logic [GEN_W-1:0]  GEN_ALL    = '1;

    typedef enum int unsigned {PH_MIXED, PH_FILL, PH_DRAIN} t_phase;
    typedef enum int unsigned {PACE_NONE, PACE_FULL, PACE_SHORT} t_pace;

    typedef struct {
        t_req req;
        bit   known;
        t_rsp want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    generational_handle_allocator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    bit               slot_live [SLOT_COUNT];
    bit [GEN_W-1:0]   slot_gen  [SLOT_COUNT];
    bit [IDX_W-1:0]   slot_pidx [SLOT_COUNT];
    bit [GEN_W-1:0]   slot_pgen [SLOT_COUNT];
    bit [IDX_W-1:0]   free_list [SLOT_COUNT];
    int unsigned      free_depth = 0;
    int unsigned      fresh_slot = 1;
    int unsigned      live_slots [$];

    t_rsp             expected_rsp [$];
    t_pace            send_pace = PACE_FULL;
    t_pace            recv_pace = PACE_FULL;
    int unsigned      mismatch_cnt = 0;
    int unsigned      checked_cnt = 0;
    int unsigned      full_answers = 0;
    int unsigned      dead_answers = 0;
    int unsigned      random_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("generational_handle_allocator_core regression: fail");
        $finish;
    end

    function automatic int unsigned draw_wait(input t_pace p);
        case (p)
            PACE_NONE:  return 0;
            PACE_FULL:  return $urandom_range(0, 17);
            default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    function automatic t_rsp allocator_step(input t_req r);
        t_rsp        rsp;
        int unsigned slot;
        bit          alive;
        rsp = '0;
        if (r.mode == MODE_CREATE) begin
            if (free_depth > 0) begin
                free_depth--;
                slot = 32'(free_list[free_depth]);
                slot_gen[slot] = slot_gen[slot] + GEN_W'(1);
            end else if (fresh_slot < SLOT_COUNT) begin
                slot = fresh_slot;
                fresh_slot++;
            end else begin
                rsp.status = ST_FULL;
                full_answers++;
                return rsp;
            end
            slot_live[slot] = 1'b1;
            live_slots.push_back(slot);
            rsp.out_index = slot[IDX_W-1:0];
            rsp.out_gen   = slot_gen[slot];
        end else if (r.mode <= MODE_GETP) begin
            alive = r.handle_index < SLOT_COUNT && slot_live[r.handle_index]
                && slot_gen[r.handle_index] == r.handle_gen;
            rsp.is_live = alive;
            if (!alive) begin
                rsp.status = ST_DEAD;
                dead_answers++;
            end else if (r.mode == MODE_DELETE) begin
                slot_pidx[r.handle_index] = '0;
                slot_pgen[r.handle_index] = '0;
                slot_live[r.handle_index] = 1'b0;
                if (free_depth < SLOT_COUNT) begin
                    free_list[free_depth] = r.handle_index;
                    free_depth++;
                end
                for (int k = 0; k < live_slots.size(); k++) begin
                    if (live_slots[k] == r.handle_index) begin
                        live_slots.delete(k);
                        break;
                    end
                end
            end else if (r.mode == MODE_SETP) begin
                slot_pidx[r.handle_index] = r.parent_index;
                slot_pgen[r.handle_index] = r.parent_gen;
            end else if (r.mode == MODE_GETP) begin
                rsp.out_index = slot_pidx[r.handle_index];
                rsp.out_gen   = slot_pgen[r.handle_index];
            end
        end
        return rsp;
    endfunction

    function automatic t_req make_request(input t_phase ph);
        t_req        r;
        int unsigned roll;
        int unsigned w_create;
        int unsigned w_delete;
        int unsigned slot;
        int unsigned link;
        r.mode         = MODE_W'($urandom_range(0, 7));
        r.handle_index = IDX_W'($urandom_range(0, IDX_TOP));
        r.handle_gen   = $urandom;
        r.parent_index = IDX_W'($urandom_range(0, IDX_TOP));
        r.parent_gen   = $urandom;
        case (ph)
            PH_FILL:  begin w_create = 82; w_delete = 0;  end
            PH_DRAIN: begin w_create = 10; w_delete = 50; end
            default:  begin w_create = 25; w_delete = 15; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll >= 90)
            return r;
        if (roll >= 82) begin
            if (free_depth > 0) begin
                slot = 32'(free_list[$urandom_range(0, free_depth - 1)]);
                r.handle_index = slot[IDX_W-1:0];
                r.handle_gen   = slot_gen[slot];
            end
            r.mode = MODE_W'(MODE_DELETE + $urandom_range(0, 3));
            return r;
        end
        if (roll < w_create || live_slots.size() == 0) begin
            r.mode = MODE_CREATE;
            return r;
        end
        slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
        r.handle_index = slot[IDX_W-1:0];
        r.handle_gen   = slot_gen[slot];
        if (roll < w_create + w_delete) begin
            r.mode = MODE_DELETE;
            return r;
        end
        case ($urandom_range(0, 3))
            0: r.mode = MODE_CHECK;
            1: begin
                r.mode = MODE_CHECK;
                r.handle_gen = slot_gen[slot] ^ (32'd1 << $urandom_range(0, GEN_W - 1));
            end
            2: begin
                r.mode = MODE_SETP;
                link = $urandom_range(0, 2);
                if (link == 0) begin
                    slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
                    r.parent_index = slot[IDX_W-1:0];
                    r.parent_gen   = slot_gen[slot];
                end else if (link == 1) begin
                    r.parent_index = '0;
                    r.parent_gen   = '0;
                end
            end
            default: r.mode = MODE_GETP;
        endcase
        return r;
    endfunction

    function automatic t_row row(input logic [MODE_W-1:0] m, input int unsigned hi,
                                 input logic [GEN_W-1:0] hg, input int unsigned pi,
                                 input logic [GEN_W-1:0] pg, input int unsigned known,
                                 input logic [STATUS_W-1:0] st, input int unsigned oi,
                                 input logic [GEN_W-1:0] og, input int unsigned lv);
        t_row t;
        t.req.mode         = m;
        t.req.handle_index = hi[IDX_W-1:0];
        t.req.handle_gen   = hg;
        t.req.parent_index = pi[IDX_W-1:0];
        t.req.parent_gen   = pg;
        t.known            = (known != 0);
        t.want.status      = st;
        t.want.out_index   = oi[IDX_W-1:0];
        t.want.out_gen     = og;
        t.want.is_live     = (lv != 0);
        return t;
    endfunction

    task automatic send_request(input t_req r, input bit known, input t_rsp want);
        t_rsp        predicted;
        int unsigned gap;
        gap = draw_wait(send_pace);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req   = r;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = allocator_step(r);
        expected_rsp.push_back(known ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic run_random(input t_phase ph);
        if (random_cnt % 64 == 0) begin
            send_pace = t_pace'($urandom_range(0, 2));
            recv_pace = t_pace'($urandom_range(0, 2));
        end
        random_cnt++;
        send_request(make_request(ph), 1'b0, '0);
    endtask

    task automatic flag_mismatch(input string what, input t_rsp want, input t_rsp got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display({"%0t %s: expected st=%0d idx=%0d gen=%h live=%0b,",
                      " got st=%0d idx=%0d gen=%h live=%0b"},
                     $time, what, want.status, want.out_index, want.out_gen, want.is_live,
                     got.status, got.out_index, got.out_gen, got.is_live);
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            checked_cnt++;
            if (expected_rsp.size() == 0) begin
                flag_mismatch("response with nothing pending", '0, o_rsp);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.status !== want.status || o_rsp.out_index !== want.out_index
                    || o_rsp.out_gen !== want.out_gen || o_rsp.is_live !== want.is_live)
                    flag_mismatch("response mismatch", want, o_rsp);
            end
        end
    end

    initial begin
        int unsigned hold;
        i_stall = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            hold = draw_wait(recv_pace);
            if (hold > 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        t_row        plan [$];
        int unsigned fill_guard;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        fill_guard = 0;

        plan.push_back(row(MODE_CHECK,  0, 0, 0, 0,             1, ST_DEAD, 0, 0, 0));
        plan.push_back(row(MODE_CREATE, 0, 0, 0, 0,             1, ST_OK,   1, 0, 0));
        plan.push_back(row(MODE_CREATE, 0, 0, 0, 0,             1, ST_OK,   2, 0, 0));
        plan.push_back(row(MODE_CREATE, 0, 0, 0, 0,             1, ST_OK,   3, 0, 0));
        plan.push_back(row(MODE_CHECK,  1, 0, 0, 0,             1, ST_OK,   0, 0, 1));
        plan.push_back(row(MODE_SETP,   2, 0, 1, 0,             1, ST_OK,   0, 0, 1));
        plan.push_back(row(MODE_GETP,   2, 0, 0, 0,             1, ST_OK,   1, 0, 1));
        plan.push_back(row(MODE_SETP,   1, 0, IDX_TOP, GEN_ALL, 1, ST_OK,   0, 0, 1));
        plan.push_back(row(MODE_GETP,   1, 0, 0, 0,             1, ST_OK,   IDX_TOP, GEN_ALL, 1));
        plan.push_back(row(MODE_DELETE, 1, 0, 0, 0,             1, ST_OK,   0, 0, 1));
        plan.push_back(row(MODE_GETP,   2, 0, 0, 0,             1, ST_OK,   1, 0, 1));
        plan.push_back(row(MODE_DELETE, 1, 0, 0, 0,             1, ST_DEAD, 0, 0, 0));
        plan.push_back(row(MODE_GETP,   1, 0, 0, 0,             1, ST_DEAD, 0, 0, 0));
        plan.push_back(row(MODE_SETP,   1, 0, 2, 0,             1, ST_DEAD, 0, 0, 0));
        plan.push_back(row(MODE_CREATE, 0, 0, 0, 0,             1, ST_OK,   1, 1, 0));
        plan.push_back(row(MODE_CHECK,  1, 0, 0, 0,             1, ST_DEAD, 0, 0, 0));
        plan.push_back(row(MODE_GETP,   1, 1, 0, 0,             1, ST_OK,   0, 0, 1));
        plan.push_back(row(MODE_DELETE, 3, 0, 0, 0,             1, ST_OK,   0, 0, 1));
        plan.push_back(row(MODE_DELETE, 2, 0, 0, 0,             1, ST_OK,   0, 0, 1));
        plan.push_back(row(MODE_CREATE, 0, 0, 0, 0,             0, ST_OK,   0, 0, 0));
        plan.push_back(row(MODE_CREATE, 0, 0, 0, 0,             0, ST_OK,   0, 0, 0));
        plan.push_back(row(MODE_RSVD5, IDX_TOP, GEN_ALL, IDX_TOP, GEN_ALL, 1, ST_OK, 0, 0, 0));
        plan.push_back(row(MODE_RSVD6, IDX_TOP, GEN_ALL, IDX_TOP, GEN_ALL, 1, ST_OK, 0, 0, 0));
        plan.push_back(row(MODE_RSVD7, IDX_TOP, GEN_ALL, IDX_TOP, GEN_ALL, 1, ST_OK, 0, 0, 0));
        plan.push_back(row(MODE_CHECK, IDX_TOP, GEN_ALL, 0, 0,  1, ST_DEAD, 0, 0, 0));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[n])
            send_request(plan[n].req, plan[n].known, plan[n].want);

        for (int k = 0; k < 150; k++)
            run_random(PH_MIXED);
        while (full_answers < 4 && fill_guard < 1500) begin
            run_random(PH_FILL);
            fill_guard++;
        end
        for (int k = 0; k < 200; k++)
            run_random(PH_DRAIN);
        i_valid = 1'b0;

        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests (%0d directed, %0d random), %0d responses checked",
                 plan.size() + random_cnt, plan.size(), random_cnt, checked_cnt);
        $display("table filled to capacity with %0d full answers, %0d not-live answers,",
                 full_answers, dead_answers);
        $display("%0d mismatches", mismatch_cnt);
        if (mismatch_cnt == 0 && expected_rsp.size() == 0) begin
            $display("generational_handle_allocator_core regression: pass");
        end else begin
            $display("generational_handle_allocator_core regression: fail");
        end
        $finish;
    end

endmodule
